/* sv/gfft_pkg.sv */
// Shared types, twiddle constants, leaf order and field multiply for the evaluator.
`default_nettype none

package gfft_pkg;

  typedef logic [7:0] gf_t;

  localparam int unsigned NumCoef = 15;
  localparam int unsigned NumLeaf = 16;

  localparam gf_t TwTable [NumLeaf] = '{
    8'd0,   8'd1,   8'd189, 8'd188, 8'd225, 8'd224, 8'd92,  8'd93,
    8'd236, 8'd237, 8'd80,  8'd81,  8'd12,  8'd13,  8'd177, 8'd176
  };

  localparam logic [3:0] LeafOrder [NumCoef] = '{
    4'd1, 4'd4, 4'd6, 4'd12, 4'd5, 4'd2, 4'd10, 4'd8,
    4'd7, 4'd9, 4'd3, 4'd14, 4'd15, 4'd11, 4'd13
  };

  // Multiplication in GF(2^8) with reduction polynomial 0x11B.
  function automatic gf_t gf_mul(gf_t a, gf_t b);
    logic [8:0] x;
    gf_t        r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ 9'h11B;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/gfft_fold.sv */
// First tree level: folds 15 coefficients into two degree-7 remainders.
`default_nettype none

module gfft_fold (
  input  wire gfft_pkg::gf_t a [gfft_pkg::NumCoef],
  output gfft_pkg::gf_t      o [gfft_pkg::NumLeaf]
);

  assign o[0]  = a[0];
  assign o[1]  = a[1] ^ a[8] ^ a[12] ^ a[14];
  assign o[2]  = a[2] ^ a[8] ^ a[9] ^ a[12] ^ a[13] ^ a[14];
  assign o[3]  = a[3] ^ a[9] ^ a[10] ^ a[13] ^ a[14];
  assign o[4]  = a[4] ^ a[8] ^ a[10] ^ a[11] ^ a[12];
  assign o[5]  = a[5] ^ a[9] ^ a[11] ^ a[12] ^ a[13];
  assign o[6]  = a[6] ^ a[10] ^ a[12] ^ a[13] ^ a[14];
  assign o[7]  = a[7] ^ a[11] ^ a[13] ^ a[14];

  assign o[8]  = a[0] ^ a[8] ^ a[12] ^ a[14];
  assign o[9]  = a[1] ^ a[8] ^ a[9] ^ a[12] ^ a[13] ^ a[14];
  assign o[10] = a[2] ^ a[8] ^ a[9] ^ a[10] ^ a[12] ^ a[13];
  assign o[11] = a[3] ^ a[9] ^ a[10] ^ a[11] ^ a[13] ^ a[14];
  assign o[12] = a[4] ^ a[8] ^ a[10] ^ a[11];
  assign o[13] = a[5] ^ a[9] ^ a[11] ^ a[12];
  assign o[14] = a[6] ^ a[10] ^ a[12] ^ a[13];
  assign o[15] = a[7] ^ a[11] ^ a[13] ^ a[14];

endmodule

`default_nettype wire

/* sv/gfft_red4_lane.sv */
// One lane of the second level: degree-7 remainder reduced modulo x^4+x+c.
`default_nettype none

module gfft_red4_lane (
  input  wire gfft_pkg::gf_t a [8],
  input  wire gfft_pkg::gf_t c,
  output gfft_pkg::gf_t      o [4]
);

  assign o[0] = a[0] ^ gfft_pkg::gf_mul(c, a[4] ^ a[7]);
  assign o[1] = a[1] ^ a[4] ^ a[7] ^ gfft_pkg::gf_mul(c, a[5]);
  assign o[2] = a[2] ^ a[5] ^ gfft_pkg::gf_mul(c, a[6]);
  assign o[3] = a[3] ^ a[6] ^ gfft_pkg::gf_mul(c, a[7]);

endmodule

`default_nettype wire

/* sv/gfft_red2_lane.sv */
// One lane of the third level: degree-3 remainder reduced modulo x^2+x+c.
`default_nettype none

module gfft_red2_lane (
  input  wire gfft_pkg::gf_t a [4],
  input  wire gfft_pkg::gf_t c,
  output gfft_pkg::gf_t      o [2]
);

  assign o[0] = a[0] ^ gfft_pkg::gf_mul(c, a[2] ^ a[3]);
  assign o[1] = a[1] ^ a[2] ^ a[3] ^ gfft_pkg::gf_mul(c, a[3]);

endmodule

`default_nettype wire

/* sv/gfft_red1_lane.sv */
// One lane of the last level: degree-1 remainder reduced modulo x+c.
`default_nettype none

module gfft_red1_lane (
  input  wire gfft_pkg::gf_t a [2],
  input  wire gfft_pkg::gf_t c,
  output gfft_pkg::gf_t      o
);

  assign o = a[0] ^ gfft_pkg::gf_mul(c, a[1]);

endmodule

`default_nettype wire

/* sv/gf256_fft15_evaluator.sv */
// Top level: four-stage pipelined reduction tree with lanes and a permuting output stage.
//
//   Channel | Handshake             | Payload
//   row     | row_valid, row_stall  | coef_lo, coef_mid, coef_high, coef_top, row_last
//   eval    | eval_valid, eval_stall| eval_lo, eval_mid, eval_high, eval_top, row_last_out
//
// One row enters per cycle while row_stall is low; its result is registered at the end of each stage.
// The stages are fold, fourth-degree lanes, second-degree lanes and first-degree
// lanes with the output permutation, each ending in a register.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close
// up while the output is stalled. Reset empties all four stages.
`default_nettype none

module gf256_fft15_evaluator (
  input  wire         clk,
  input  wire         rst,
  input  wire         row_valid,
  output logic        row_stall,
  input  wire  [31:0] coef_lo,
  input  wire  [31:0] coef_mid,
  input  wire  [31:0] coef_high,
  input  wire  [23:0] coef_top,
  input  wire         row_last,
  output logic        eval_valid,
  input  wire         eval_stall,
  output logic [31:0] eval_lo,
  output logic [31:0] eval_mid,
  output logic [31:0] eval_high,
  output logic [23:0] eval_top,
  output logic        row_last_out
);

  gfft_pkg::gf_t coef [gfft_pkg::NumCoef];
  gfft_pkg::gf_t fold_out [gfft_pkg::NumLeaf];
  gfft_pkg::gf_t red4_out [gfft_pkg::NumLeaf];
  gfft_pkg::gf_t red2_out [gfft_pkg::NumLeaf];
  gfft_pkg::gf_t leaf [gfft_pkg::NumLeaf];

  gfft_pkg::gf_t s8 [gfft_pkg::NumLeaf];
  gfft_pkg::gf_t s4 [gfft_pkg::NumLeaf];
  gfft_pkg::gf_t s2 [gfft_pkg::NumLeaf];
  gfft_pkg::gf_t ev [gfft_pkg::NumCoef];

  logic [3:0] vld;
  logic [3:0] lst;
  logic [3:0] rdy;

  for (genvar k = 0; k < 4; k++) begin : g_unpack
    assign coef[k]     = coef_lo[8*k +: 8];
    assign coef[4 + k] = coef_mid[8*k +: 8];
    assign coef[8 + k] = coef_high[8*k +: 8];
  end
  for (genvar k = 0; k < 3; k++) begin : g_unpack_top
    assign coef[12 + k] = coef_top[8*k +: 8];
  end

  assign rdy[3]    = !vld[3] || !eval_stall;
  assign rdy[2]    = !vld[2] || rdy[3];
  assign rdy[1]    = !vld[1] || rdy[2];
  assign rdy[0]    = !vld[0] || rdy[1];
  assign row_stall = !rdy[0];

  gfft_fold u_fold (
    .a (coef),
    .o (fold_out)
  );

  for (genvar i = 0; i < 4; i++) begin : g_red4
    gfft_pkg::gf_t la [8];
    gfft_pkg::gf_t lo [4];
    for (genvar j = 0; j < 8; j++) begin : g_in
      assign la[j] = s8[8 * (i / 2) + j];
    end
    gfft_red4_lane u_lane (
      .a (la),
      .c (gfft_pkg::TwTable[i]),
      .o (lo)
    );
    for (genvar j = 0; j < 4; j++) begin : g_out
      assign red4_out[4 * i + j] = lo[j];
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_red2
    gfft_pkg::gf_t la [4];
    gfft_pkg::gf_t lo [2];
    for (genvar j = 0; j < 4; j++) begin : g_in
      assign la[j] = s4[4 * (i / 2) + j];
    end
    gfft_red2_lane u_lane (
      .a (la),
      .c (gfft_pkg::TwTable[i]),
      .o (lo)
    );
    for (genvar j = 0; j < 2; j++) begin : g_out
      assign red2_out[2 * i + j] = lo[j];
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_red1
    gfft_pkg::gf_t la [2];
    for (genvar j = 0; j < 2; j++) begin : g_in
      assign la[j] = s2[2 * (i / 2) + j];
    end
    gfft_red1_lane u_lane (
      .a (la),
      .c (gfft_pkg::TwTable[i]),
      .o (leaf[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= row_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s8     <= fold_out;
      lst[0] <= row_last;
    end
    if (rdy[1]) begin
      s4     <= red4_out;
      lst[1] <= lst[0];
    end
    if (rdy[2]) begin
      s2     <= red2_out;
      lst[2] <= lst[1];
    end
    if (rdy[3]) begin
      for (int j = 0; j < 15; j++) begin
        ev[j] <= leaf[gfft_pkg::LeafOrder[j]];
      end
      lst[3] <= lst[2];
    end
  end

  assign eval_valid   = vld[3];
  assign row_last_out = lst[3];
  assign eval_lo      = {ev[3], ev[2], ev[1], ev[0]};
  assign eval_mid     = {ev[7], ev[6], ev[5], ev[4]};
  assign eval_high    = {ev[11], ev[10], ev[9], ev[8]};
  assign eval_top     = {ev[14], ev[13], ev[12]};

endmodule

`default_nettype wire
